// ===== hdl/iss_pkg.sv =====
`timescale 1ns / 1ps

package iss_pkg;

    // Default number of stored values
    localparam int CAPACITY_DEFAULT = 16;

    // Fixed field widths of the request and response
    localparam int ACTION_W  = 2;
    localparam int ELEMENT_W = 32;
    localparam int COUNT_W   = 5;

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // capture request, restart the scan at entry 0
        logic idx_inc;      // advance the scan / shift index
        logic set_found;    // mark the element as present
        logic append;       // write the element after the last entry, bump count
        logic reject;       // flag a refused add
        logic shift_wr;     // move the entry at index down one place
        logic dec_count;    // drop one from the count
        logic clear_count;  // empty the store
        logic out_load;     // present the result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        action_t action;    // captured action
        logic    empty;     // no entries stored
        logic    full;      // count at capacity
        logic    hit;       // entry at index matches the element
        logic    more;      // an entry exists past the index
        logic    found;     // element was located
        logic    out_free;  // result register can take a new result
    } status_t;

endpackage

// ===== hdl/iss_req_if.sv =====
`timescale 1ns / 1ps

interface iss_req_if;
    logic                            valid;
    logic                            ready;
    logic [iss_pkg::ACTION_W-1:0]    action;
    logic signed [iss_pkg::ELEMENT_W-1:0] element;

    modport source (output valid, output action, output element, input ready);
    modport sink   (input valid, input action, input element, output ready);
endinterface

// ===== hdl/iss_rsp_if.sv =====
`timescale 1ns / 1ps

interface iss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [iss_pkg::COUNT_W-1:0]  count;
    logic                         rejected;

    modport source (output valid, output found, output count, output rejected, input ready);
    modport sink   (input valid, input found, input count, input rejected, output ready);
endinterface

// ===== hdl/iss_datapath.sv =====
`timescale 1ns / 1ps

module iss_datapath #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  iss_pkg::cmd_t       cmd,
    output iss_pkg::status_t    status,
    iss_req_if.sink             req,
    iss_rsp_if.source           rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry storage
    logic [iss_pkg::ELEMENT_W-1:0] mem [CAPACITY];
    logic [iss_pkg::ELEMENT_W-1:0] rd_data_reg;

    // Request and scan registers
    iss_pkg::action_t              action_reg;
    logic [iss_pkg::ELEMENT_W-1:0] element_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          found_reg;
    logic                          reject_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [iss_pkg::COUNT_W-1:0]   out_count_reg;
    logic                          out_reject_reg;

    logic [CNT_W-1:0]              idx_plus1;
    logic [IDX_W-1:0]              wr_addr;
    logic [iss_pkg::ELEMENT_W-1:0] wr_data;
    logic                          wr_en;

    // Select the index the memory reads for the next cycle
    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);

    // Pick the write: append at the end, or move an entry down one place
    always_comb
    begin
        wr_en   = cmd.append || cmd.shift_wr;
        wr_addr = cmd.append ? count_reg[IDX_W-1:0] : (idx_reg - IDX_W'(1));
        wr_data = cmd.append ? element_reg : rd_data_reg;
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_next];
    end

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Capture the request and track the per-transaction flags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= iss_pkg::action_t'(req.action);
            element_reg <= req.element;
            found_reg   <= 1'b0;
            reject_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.reject)
            begin
                reject_reg <= 1'b1;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg  <= found_reg;
            out_count_reg  <= iss_pkg::COUNT_W'(count_reg);
            out_reject_reg <= reject_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.rejected = out_reject_reg;

    // Status back to the controller
    always_comb
    begin
        status.action   = action_reg;
        status.empty    = (count_reg == '0);
        status.full     = (count_reg == CNT_W'(CAPACITY));
        status.hit      = (rd_data_reg == element_reg);
        status.more     = (idx_plus1 < count_reg);
        status.found    = found_reg;
        status.out_free = !out_valid_reg || rsp.ready;
    end

endmodule

// ===== hdl/iss_ctrl.sv =====
`timescale 1ns / 1ps

module iss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  iss_pkg::status_t    status,
    output iss_pkg::cmd_t       cmd
);

    iss_pkg::state_t state_reg;
    iss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        unique case (state_reg)
            iss_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = iss_pkg::ST_SCAN;
                end
            end

            // Walk the stored entries until a match or the last one; a clear skips the walk
            iss_pkg::ST_SCAN:
            begin
                if (status.action == iss_pkg::ACT_CLEAR)
                begin
                    cmd.clear_count = 1'b1;
                    state_next      = iss_pkg::ST_DONE;
                end
                else if (status.empty)
                begin
                    state_next = iss_pkg::ST_UPDATE;
                end
                else if (status.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = iss_pkg::ST_UPDATE;
                end
                else if (!status.more)
                begin
                    state_next = iss_pkg::ST_UPDATE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            // Apply the action once the position is known
            iss_pkg::ST_UPDATE:
            begin
                state_next = iss_pkg::ST_DONE;
                case (status.action)
                    iss_pkg::ACT_ADD:
                    begin
                        if (!status.found)
                        begin
                            if (status.full)
                            begin
                                cmd.reject = 1'b1;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                        end
                    end
                    iss_pkg::ACT_REMOVE:
                    begin
                        if (status.found)
                        begin
                            if (status.more)
                            begin
                                cmd.idx_inc = 1'b1;
                                state_next  = iss_pkg::ST_SHIFT;
                            end
                            else
                            begin
                                cmd.dec_count = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Move later entries down one place each cycle
            iss_pkg::ST_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (status.more)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = iss_pkg::ST_DONE;
                end
            end

            // Hand the result over when the result register is free
            iss_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = iss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = iss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/integer_set_store.sv =====
`timescale 1ns / 1ps
// Set of up to CAPACITY distinct signed 32-bit values kept in insertion order.
// Request channel (req): action (add, remove, query, clear) and element.
// Response channel (rsp): found (element present before the request), count
// (values stored after it, low 5 bits) and rejected (add refused, store full).
// Every request gives exactly one response, in request order.
// A request other than a clear scans the stored entries one per cycle from
// the first, stopping at a match; a remove then shifts each later entry down
// one place per cycle. The entry memory has a single read port, which sets
// this pace. One request is in work at a time.
// The request channel reopens as soon as the response is registered, so the
// next request is taken while the previous response still waits.
// When the receiver stalls, the response holds and the next request is worked
// up to its final step, where it waits for the response register to empty.
// Reset empties the store (count zero) and drops any pending response; entry
// contents are not cleared, and the block is ready at once.
module integer_set_store #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    iss_req_if.sink     req,
    iss_rsp_if.source   rsp
);

    iss_pkg::cmd_t    cmd;
    iss_pkg::status_t status;

    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    iss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule

// ===== hdl/iss_checker.sv =====
`timescale 1ns / 1ps

module iss_checker #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_found,
    input logic [iss_pkg::COUNT_W-1:0]  rsp_count,
    input logic                         rsp_rejected
);

    // A stalled response holds its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_count) && $stable(rsp_rejected))
        else $error("response changed while stalled");

    // One request in work at a time: the request side closes after a transaction
    a_req_close: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // A refused add means the element was absent and the store is full
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rejected |->
            !rsp_found && ((CAPACITY > 31) || (rsp_count == iss_pkg::COUNT_W'(CAPACITY))))
        else $error("rejected add with element present or store not full");

    // The count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 31) || (rsp_count <= iss_pkg::COUNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind integer_set_store iss_checker #(
    .CAPACITY (CAPACITY)
) u_iss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_count    (rsp.count),
    .rsp_rejected (rsp.rejected)
);
